FILE: src/crmt_pkg.sv
`timescale 1ns / 1ps
// Package for the CAN receive mailbox table: transaction structs, item kind codes,
// controller states and the byte masking helper. Depends on nothing.
package crmt_pkg;

  localparam int ID_W   = 11;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int SLOT_W = 5;
  localparam int KIND_W = 2;
  localparam int STORE_W = LEN_W + DATA_W;

  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POLL   = 2'd2;

  localparam logic [LEN_W-1:0] MAX_LEN   = 4'd8;
  localparam logic [7:0]       BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] frame_data;
  } in_item_t;

  typedef struct packed {
    logic              received;
    logic [ID_W-1:0]   out_id;
    logic [LEN_W-1:0]  out_len;
    logic [DATA_W-1:0] out_data;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POLL
  } ctrl_state_t;

  // Commands to the per-slot flag bits.
  typedef struct packed {
    logic assign_en;  // mark assigned and clear fresh
    logic set_en;     // set fresh on a matching frame
    logic clr_en;     // clear fresh on a poll
  } flag_cmd_t;

  // Clears every data byte at or above the given length.
  function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] data,
                                                   input logic [LEN_W-1:0]  len);
    logic [DATA_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      if (LEN_W'(b) < len) begin
        mask[8*b +: 8] = BYTE_MASK;
      end
    end
    return data & mask;
  endfunction

endpackage

FILE: src/crmt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module crmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/crmt_flags.sv
`timescale 1ns / 1ps
// Per-slot assigned and fresh bits, held in flip-flops so that reset clears them at once.
// Depends on crmt_pkg.
module crmt_flags import crmt_pkg::*; #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  flag_cmd_t                     cmd,
  input  logic [$clog2(SLOT_COUNT)-1:0] assign_idx,
  input  logic [$clog2(SLOT_COUNT)-1:0] set_idx,
  input  logic [$clog2(SLOT_COUNT)-1:0] clr_idx,
  input  logic [$clog2(SLOT_COUNT)-1:0] fresh_idx,
  input  logic [$clog2(SLOT_COUNT)-1:0] assigned_idx,
  output logic                          fresh,
  output logic                          assigned
);

  logic [SLOT_COUNT-1:0] assigned_r, assigned_nxt;
  logic [SLOT_COUNT-1:0] fresh_r, fresh_nxt;

  always_comb begin
    assigned_nxt = assigned_r;
    fresh_nxt    = fresh_r;
    if (cmd.assign_en) begin
      assigned_nxt[assign_idx] = 1'b1;
      fresh_nxt[assign_idx]    = 1'b0;
    end
    if (cmd.set_en) begin
      fresh_nxt[set_idx] = 1'b1;
    end
    if (cmd.clr_en) begin
      fresh_nxt[clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assigned_r <= '0;
      fresh_r    <= '0;
    end else begin
      assigned_r <= assigned_nxt;
      fresh_r    <= fresh_nxt;
    end
  end

  assign fresh    = fresh_r[fresh_idx];
  assign assigned = assigned_r[assigned_idx];

endmodule

FILE: src/can_receive_mailbox_table.sv
`timescale 1ns / 1ps
// Top level of the CAN receive mailbox table.
// Depends on crmt_pkg, crmt_ram and crmt_flags.

// The block keeps SLOT_COUNT receive mailboxes for standard 11-bit CAN frames. An assign
// transaction binds a slot to an identifier without stalling the input. A received frame is
// compared with every assigned slot in turn through the single read port of the
// identifier RAM, so the input stays stalled after a frame is accepted until the last
// slot has been compared; no new transaction is taken during that scan.
// A poll transaction reads the stored frame, and its result sits in an output register,
// so the next transaction can be accepted while the result waits.
// Each matching slot stores the frame length, clamped to eight, and the data bytes below
// that length, with the bytes above it cleared. A poll of a slot outside the table
// returns a result of all zeros. Kind code 3 is accepted and ignored.
module can_receive_mailbox_table import crmt_pkg::*; #(
  parameter int SLOT_COUNT = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  // Wide enough for both the slot field and the table size itself.
  localparam int CMP_W = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  ctrl_state_t state_r, state_nxt;

  // Frame captured at acceptance, used for the whole scan.
  logic [ID_W-1:0]    frame_id_r, frame_id_nxt;
  logic [STORE_W-1:0] frame_store_r, frame_store_nxt;

  // Scan pointers: the read issue stage and the compare stage, which trails it by a register.
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             issue_done_r, issue_done_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  // Poll bookkeeping: was the polled slot in range and fresh.
  logic poll_hit_r, poll_hit_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // Slot field decode.
  logic [CMP_W-1:0] slot_wide;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_in_range;
  logic [LEN_W-1:0] len_clamped;

  // Memory and flag connections.
  logic               id_we, id_re;
  logic [IDX_W-1:0]   id_raddr;
  logic [ID_W-1:0]    id_rdata;
  logic               st_we, st_re;
  logic [STORE_W-1:0] st_rdata;
  flag_cmd_t          flag_cmd;
  logic               flag_fresh, flag_assigned;
  logic               accept, match;

  assign slot_wide     = CMP_W'(in_item.slot);
  assign slot_idx      = slot_wide[IDX_W-1:0];
  assign slot_in_range = slot_wide < CMP_W'(SLOT_COUNT);
  assign len_clamped   = (in_item.frame_len > MAX_LEN) ? MAX_LEN : in_item.frame_len;

  // The input side is open only while no frame scan or poll read is under way.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // A slot takes the frame when it is assigned and its identifier matches.
  assign match = cmp_valid_r && flag_assigned && (id_rdata == frame_id_r);

  always_comb begin
    state_nxt       = state_r;
    frame_id_nxt    = frame_id_r;
    frame_store_nxt = frame_store_r;
    scan_idx_nxt    = scan_idx_r;
    issue_done_nxt  = issue_done_r;
    cmp_valid_nxt   = 1'b0;
    cmp_idx_nxt     = scan_idx_r;
    poll_hit_nxt    = poll_hit_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_item_nxt    = out_item_r;
    id_we           = 1'b0;
    id_re           = 1'b0;
    id_raddr        = scan_idx_r;
    st_re           = 1'b0;
    st_we           = match;
    flag_cmd        = '0;
    flag_cmd.set_en = match;

    unique case (state_r)
      ST_IDLE: begin
        id_raddr = slot_idx;
        if (accept) begin
          priority if (in_item.kind == KIND_FRAME) begin
            frame_id_nxt    = in_item.frame_id;
            frame_store_nxt = {len_clamped, keep_bytes(in_item.frame_data, len_clamped)};
            scan_idx_nxt    = '0;
            issue_done_nxt  = 1'b0;
            state_nxt       = ST_SCAN;
          end else if (in_item.kind == KIND_ASSIGN) begin
            id_we              = slot_in_range;
            flag_cmd.assign_en = slot_in_range;
          end else if (in_item.kind == KIND_POLL) begin
            id_re           = 1'b1;
            st_re           = 1'b1;
            poll_hit_nxt    = slot_in_range && flag_fresh;
            flag_cmd.clr_en = slot_in_range;
            state_nxt       = ST_POLL;
          end else begin
            // Reserved kind: nothing happens.
          end
        end
      end
      ST_SCAN: begin
        if (!issue_done_r) begin
          id_re         = 1'b1;
          cmp_valid_nxt = 1'b1;
          if (scan_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
          end
        end
        if (cmp_valid_r && (cmp_idx_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POLL: begin
        // The RAM read data holds until the output register has room.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.received = poll_hit_r;
          out_item_nxt.out_id   = poll_hit_r ? id_rdata : '0;
          out_item_nxt.out_len  = poll_hit_r ? st_rdata[STORE_W-1 -: LEN_W] : '0;
          out_item_nxt.out_data = poll_hit_r ? st_rdata[DATA_W-1:0] : '0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      cmp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_id_r    <= frame_id_nxt;
    frame_store_r <= frame_store_nxt;
    scan_idx_r    <= scan_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    poll_hit_r    <= poll_hit_nxt;
    out_item_r    <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Identifier of every slot. Its value only counts once the slot is assigned, so it needs no clear.
  crmt_ram #(
    .WIDTH(ID_W),
    .DEPTH(SLOT_COUNT)
  ) u_ident_ram (
    .clk  (clk),
    .we   (id_we),
    .waddr(slot_idx),
    .wdata(in_item.frame_id),
    .re   (id_re),
    .raddr(id_raddr),
    .rdata(id_rdata)
  );

  // Stored length and data bytes, written by the scan and read by a poll.
  crmt_ram #(
    .WIDTH(STORE_W),
    .DEPTH(SLOT_COUNT)
  ) u_store_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(cmp_idx_r),
    .wdata(frame_store_r),
    .re   (st_re),
    .raddr(slot_idx),
    .rdata(st_rdata)
  );

  crmt_flags #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_flags (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (flag_cmd),
    .assign_idx  (slot_idx),
    .set_idx     (cmp_idx_r),
    .clr_idx     (slot_idx),
    .fresh_idx   (slot_idx),
    .assigned_idx(cmp_idx_r),
    .fresh       (flag_fresh),
    .assigned    (flag_assigned)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CAN receive mailbox table (can_receive_mailbox_table).
// Depends on crmt_pkg for the transaction structs and item kind codes.

module testbench;
  import crmt_pkg::*;

  // The table is built with its default size. The slot field is five bits wide, so with
  // 32 slots no slot index can fall outside the table.
  localparam int MBOX_COUNT = 32;

  // Kind code 3 has no name in the package. The block accepts it and does nothing.
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  // Number of frame, assign and poll transactions in the random part.
  localparam int RANDOM_ITEMS = 1100;

  // A received frame keeps the input stalled until its scan of every slot is done. This margin covers
  // that scan with room to spare before the final check.
  localparam int DRAIN_CYCLES = MBOX_COUNT + 16;

  // One entry of the driver's feed: the transaction, the idle cycles that go before it,
  // and whether the driver must first wait until every poll result has come back.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
    bit          wait_empty;
  } feed_entry_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  can_receive_mailbox_table #(
    .SLOT_COUNT(MBOX_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Mailbox shadow. The testbench keeps its own copy of every slot and updates it at the
  // moment a transaction is accepted. Length and data of a slot are only read while its
  // fresh mark is set, and the mark is set in the same step that writes both.
  // ---------------------------------------------------------------------------------------
  logic [ID_W-1:0]   mbox_ident [MBOX_COUNT] = '{default: '0};
  bit                mbox_bound [MBOX_COUNT];
  bit                mbox_fresh [MBOX_COUNT];
  logic [LEN_W-1:0]  mbox_len   [MBOX_COUNT];
  logic [DATA_W-1:0] mbox_bytes [MBOX_COUNT];

  // Poll results in the order the block must deliver them.
  out_item_t poll_results_due[$];

  feed_entry_t feed_q[$];

  int failures      = 0;
  int items_taken   = 0;
  int polls_checked = 0;
  int fresh_returns = 0;

  // Applies one accepted transaction to the shadow and queues the poll result it causes.
  function automatic void predict_item(input in_item_t it);
    logic [LEN_W-1:0]  clamped_len;
    logic [DATA_W-1:0] byte_keep;
    out_item_t         res;
    case (it.kind)
      KIND_FRAME: begin
        // Lengths above eight are stored as eight; bytes at or above the length read zero.
        clamped_len = (it.frame_len > MAX_LEN) ? MAX_LEN : it.frame_len;
        byte_keep = '0;
        for (int b = 0; b < 8; b++) begin
          if (b < clamped_len) begin
            byte_keep[8*b +: 8] = 8'hFF;
          end
        end
        // Every assigned slot with a matching identifier takes the frame.
        for (int s = 0; s < MBOX_COUNT; s++) begin
          if (mbox_bound[s] && mbox_ident[s] == it.frame_id) begin
            mbox_fresh[s] = 1'b1;
            mbox_len[s]   = clamped_len;
            mbox_bytes[s] = it.frame_data & byte_keep;
          end
        end
      end
      KIND_ASSIGN: begin
        if (it.slot < MBOX_COUNT) begin
          mbox_ident[it.slot] = it.frame_id;
          mbox_bound[it.slot] = 1'b1;
          mbox_fresh[it.slot] = 1'b0;
        end
      end
      KIND_POLL: begin
        // A slot that is not fresh, or lies outside the table, returns all zeros.
        res = '0;
        if (it.slot < MBOX_COUNT && mbox_fresh[it.slot]) begin
          mbox_fresh[it.slot] = 1'b0;
          res.received = 1'b1;
          res.out_id   = mbox_ident[it.slot];
          res.out_len  = mbox_len[it.slot];
          res.out_data = mbox_bytes[it.slot];
        end
        poll_results_due.push_back(res);
      end
      default: begin
        // Unused kind: no effect on any slot and no result.
      end
    endcase
  endfunction

  // Compares one accepted result with the oldest poll result still due.
  function automatic void check_poll_result(input out_item_t got);
    out_item_t want;
    if (poll_results_due.size() == 0) begin
      $error("result transaction with no poll outstanding: received=%0d id=%h len=%0d data=%h",
             got.received, got.out_id, got.out_len, got.out_data);
      failures++;
      return;
    end
    want = poll_results_due.pop_front();
    if (got.received !== want.received) begin
      $error("received: expected %0d, got %0d", want.received, got.received);
      failures++;
    end
    if (got.out_id !== want.out_id) begin
      $error("out_id: expected %h, got %h", want.out_id, got.out_id);
      failures++;
    end
    if (got.out_len !== want.out_len) begin
      $error("out_len: expected %0d, got %0d", want.out_len, got.out_len);
      failures++;
    end
    if (got.out_data !== want.out_data) begin
      $error("out_data: expected %h, got %h", want.out_data, got.out_data);
      failures++;
    end
    if (want.received) begin
      fresh_returns++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver. A transaction is accepted at an edge where in_valid is high and in_stall low;
  // the shadow is updated right there. While the block stalls, the payload is held.
  // Otherwise the next feed entry is presented once its idle gap has run out and, for
  // entries that ask for it, once no poll result is outstanding.
  // ---------------------------------------------------------------------------------------
  int unsigned idle_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      idle_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_item);
        items_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (feed_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_count < feed_q[0].gap) begin
          idle_count <= idle_count + 1;
          in_valid   <= 1'b0;
        end else if (feed_q[0].wait_empty && poll_results_due.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          in_item    <= feed_q[0].item;
          in_valid   <= 1'b1;
          idle_count <= 0;
          void'(feed_q.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. After each accepted result a fresh random stall length is drawn.
  // The stall only counts down while a result is waiting, so it always lands on one.
  // A stretch of results in the middle of the run is taken without any stall.
  // ---------------------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_poll_result(out_item);
        polls_checked++;
        stall_left = (polls_checked >= 150 && polls_checked < 230) ? 0 : $urandom_range(0, 19);
      end else if (out_valid && stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------------------
  bit          no_gaps = 1'b0;
  logic [10:0] id_pool [8];

  function automatic void add_item(input logic [KIND_W-1:0] kind, input int slot,
                                   input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                                   input logic [DATA_W-1:0] data, input bit wait_empty = 0);
    feed_entry_t e;
    e.item.kind       = kind;
    e.item.slot       = slot[SLOT_W-1:0];
    e.item.frame_id   = id;
    e.item.frame_len  = len;
    e.item.frame_data = data;
    e.gap             = no_gaps ? 0 : $urandom_range(0, 19);
    e.wait_empty      = wait_empty;
    feed_q.push_back(e);
  endfunction

  function automatic void refresh_id_pool();
    for (int p = 0; p < 8; p++) begin
      id_pool[p] = 11'($urandom_range(0, 2047));
    end
    // Keep the identifier extremes in play now and then.
    if ($urandom_range(0, 2) == 0) begin
      id_pool[0] = '0;
      id_pool[1] = '1;
    end
  endfunction

  function automatic logic [DATA_W-1:0] random_bytes();
    return {$urandom, $urandom};
  endfunction

  function automatic void build_directed();
    // Polls on an empty table return all zeros, at both ends of the slot range.
    add_item(KIND_POLL, 0, '0, '0, '0);
    add_item(KIND_POLL, 31, '1, '1, '1);
    // Identifier 0 equals the starting identifier of every slot in the shadow, but unassigned slots must
    // never take a frame.
    add_item(KIND_FRAME, 0, '0, 4'd8, '1);
    add_item(KIND_POLL, 0, '0, '0, '0);
    // Two slots bound to the same identifier both take the next matching frame.
    add_item(KIND_ASSIGN, 0, 11'h7FF, '0, '0);
    add_item(KIND_ASSIGN, 31, 11'h7FF, '0, '0);
    add_item(KIND_ASSIGN, 5, 11'h000, '0, '0);
    // Length 15 is clamped to eight.
    add_item(KIND_FRAME, 0, 11'h7FF, 4'd15, '1);
    add_item(KIND_POLL, 0, '0, '0, '0);
    add_item(KIND_POLL, 31, '0, '0, '0);
    // A second poll finds the fresh mark already cleared.
    add_item(KIND_POLL, 0, '0, '0, '0);
    // Short frame: bytes at and above the length come back as zero.
    add_item(KIND_FRAME, 17, 11'h000, 4'd3, '1);
    add_item(KIND_POLL, 5, '0, '0, '0);
    // A zero-length frame, then a rebind of the same slot clears its fresh mark.
    add_item(KIND_FRAME, 0, 11'h000, 4'd0, random_bytes());
    add_item(KIND_ASSIGN, 5, 11'h000, '0, '0);
    add_item(KIND_POLL, 5, '0, '0, '0);
    // The unused kind changes nothing and returns nothing.
    add_item(KIND_IGNORED, 0, 11'h7FF, 4'd8, '1);
    add_item(KIND_IGNORED, 31, '1, '1, '1);
    // Length nine is clamped too; rebinding slot 31 drops its pending frame.
    add_item(KIND_FRAME, 0, 11'h7FF, 4'd9, random_bytes());
    add_item(KIND_ASSIGN, 31, 11'h123, '0, '0);
    add_item(KIND_POLL, 31, '0, '0, '0);
    add_item(KIND_POLL, 0, '0, '0, '0);
    // The sender holds this poll back until every poll before it has been answered.
    add_item(KIND_POLL, 5, '0, '0, '0, 1'b1);
  endfunction

  // Mostly well-formed traffic: slots are bound to identifiers from a small pool, so most
  // frames hit at least one slot and most polls find something. The rest is noise:
  // frames with arbitrary identifiers, lengths above eight and the unused kind.
  function automatic void build_random();
    int          counted;
    int unsigned pick;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    counted = 0;
    refresh_id_pool();
    while (counted < RANDOM_ITEMS) begin
      if (counted % 150 == 0) begin
        refresh_id_pool();
      end
      // Two stretches go without any sender gaps.
      no_gaps = (counted >= 300 && counted < 400) || (counted >= 800 && counted < 880);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        add_item(KIND_ASSIGN, $urandom_range(0, MBOX_COUNT - 1), id_pool[$urandom_range(0, 7)],
                 4'($urandom_range(0, 15)), random_bytes());
        counted++;
      end else if (pick < 55) begin
        id  = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 7)]
                                           : 11'($urandom_range(0, 2047));
        len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        add_item(KIND_FRAME, $urandom_range(0, MBOX_COUNT - 1), id, len, random_bytes());
        counted++;
      end else if (pick < 96) begin
        // Pressure points: at two places in the run, hold the sender until every outstanding poll has been answered.
        add_item(KIND_POLL, $urandom_range(0, MBOX_COUNT - 1), 11'($urandom_range(0, 2047)),
                 4'($urandom_range(0, 15)), random_bytes(), counted == 0 || counted == 600);
        counted++;
      end else begin
        add_item(KIND_IGNORED, $urandom_range(0, MBOX_COUNT - 1), 11'($urandom_range(0, 2047)),
                 4'($urandom_range(0, 15)), random_bytes());
      end
    end
    no_gaps = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Run control: fill the feed, reset once, wait for the traffic to drain, report.
  // ---------------------------------------------------------------------------------------
  initial begin
    build_directed();
    build_random();
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (feed_q.size() != 0 || in_valid || poll_results_due.size() != 0) begin
      @(posedge clk);
    end
    // A frame accepted last may still be scanning; let it finish before the final check.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (poll_results_due.size() != 0) begin
      $error("%0d poll results never arrived", poll_results_due.size());
      failures++;
    end
    $display("Covered %0d accepted transactions (frames, assigns, polls, unused kind).",
             items_taken);
    $display("Checked %0d poll results, %0d of them carrying a fresh frame.",
             polls_checked, fresh_returns);
    if (failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run (about 0.1 ms of traffic per 150 items).
  initial begin
    #5_000_000;
    $display("timeout waiting for the block to finish");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
src/crmt_pkg.sv
src/crmt_ram.sv
src/crmt_flags.sv
src/can_receive_mailbox_table.sv
tb/testbench.sv
